/* hw/rtl/prac_pkg.sv */
// shared constants, types and the arctangent table for the point rotation block
// depends on nothing; every other rtl file but prac_if imports it
`default_nettype none

package prac_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int COORD_BITS    = 32;

  // effective coordinate width and stage count
  localparam int CW      = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int NSTAGES = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

  localparam int GUARD      = 8;
  localparam int GAIN_SHIFT = 30 - GUARD;
  localparam int DW = CW + 1;            // offset from center
  localparam int PW = DW + 32;           // offset times gain
  localparam int XW = CW + 11;           // rotator x / y
  localparam int ZW = 33;                // residual angle
  localparam int RW = XW - GUARD;        // rounded offset

  localparam logic signed [31:0] GAIN_Q30     = 32'sd652032874;
  localparam logic [31:0]        QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0]        HALF_TURN    = 32'h8000_0000;
  localparam logic [XW-1:0]      ROUND_HALF   = XW'(1 << (GUARD - 1));

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef logic [1:0] reg_addr_t;
  localparam reg_addr_t REG_CENTER_X   = 2'd0;
  localparam reg_addr_t REG_CENTER_Y   = 2'd1;
  localparam reg_addr_t REG_ANG_VEL    = 2'd2;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t;
    case (i)
      0:       t = 32'h20000000;
      1:       t = 32'h12E4051E;
      2:       t = 32'h09FB385B;
      3:       t = 32'h051111D4;
      4:       t = 32'h028B0D43;
      5:       t = 32'h0145D7E1;
      6:       t = 32'h00A2F61E;
      7:       t = 32'h00517C55;
      8:       t = 32'h0028BE53;
      9:       t = 32'h00145F2F;
      10:      t = 32'h000A2F98;
      11:      t = 32'h000517CC;
      12:      t = 32'h00028BE6;
      13:      t = 32'h000145F3;
      14:      t = 32'h0000A2FA;
      15:      t = 32'h0000517D;
      16:      t = 32'h000028BE;
      17:      t = 32'h0000145F;
      18:      t = 32'h00000A30;
      19:      t = 32'h00000518;
      20:      t = 32'h0000028C;
      21:      t = 32'h00000146;
      22:      t = 32'h000000A3;
      23:      t = 32'h00000051;
      24:      t = 32'h00000029;
      25:      t = 32'h00000014;
      26:      t = 32'h0000000A;
      27:      t = 32'h00000005;
      28:      t = 32'h00000003;
      29:      t = 32'h00000001;
      30:      t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/prac_if.sv */
// valid/ready channel interfaces: point requests, results, register writes
// depends on nothing
`default_nettype none

interface prac_pt_if;
  logic        valid;
  logic        ready;
  logic [15:0] elapsed_ms;
  logic [31:0] prev_x;
  logic [31:0] prev_y;

  modport source (output valid, output elapsed_ms, output prev_x, output prev_y,
                  input ready);
  modport sink   (input valid, input elapsed_ms, input prev_x, input prev_y,
                  output ready);
endinterface

interface prac_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_x;
  logic [31:0] next_y;
  logic        saturated;

  modport source (output valid, output next_x, output next_y, output saturated,
                  input ready);
  modport sink   (input valid, input next_x, input next_y, input saturated,
                  output ready);
endinterface

interface prac_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [31:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/prac_front.sv */
// front end: offset and angle product, gain multiply, quadrant pre-rotation
// depends on prac_pkg and prac_pt_if
`default_nettype none

module prac_front (
  input  wire logic              clk,
  input  wire logic              rst,
  prac_pt_if.sink                pt,
  input  wire logic [31:0]       center_x,
  input  wire logic [31:0]       center_y,
  input  wire logic [31:0]       angular_velocity,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output prac_pkg::rot_t         out_data
);
  import prac_pkg::*;

  // stage a: offset and angle
  logic                 va;
  logic signed [DW-1:0] a_dx;
  logic signed [DW-1:0] a_dy;
  logic [31:0]          a_angle;
  // stage b: gain products
  logic                 vb;
  logic signed [PW-1:0] b_px;
  logic signed [PW-1:0] b_py;
  logic [31:0]          b_angle;
  // stage c: pre-rotated vector
  logic                 vc;
  rot_t                 c_data;

  logic ra, rb, rc;

  logic signed [CW-1:0] px_c, py_c, cx_c, cy_c;
  logic [47:0]          angle_prod;
  logic signed [PW-1:0] prod_x, prod_y;
  logic signed [XW-1:0] x0, y0;
  logic signed [XW-1:0] x0e, y0e;
  logic                 flip;
  logic [31:0]          angle_sum, z_bits;
  rot_t                 c_next;

  assign rc = !vc || out_ready;
  assign rb = !vb || rc;
  assign ra = !va || rb;
  assign pt.ready = ra;

  assign px_c = $signed(pt.prev_x[CW-1:0]);
  assign py_c = $signed(pt.prev_y[CW-1:0]);
  assign cx_c = $signed(center_x[CW-1:0]);
  assign cy_c = $signed(center_y[CW-1:0]);
  assign angle_prod = angular_velocity * pt.elapsed_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ra) begin
      va <= pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ra && pt.valid) begin
      a_dx    <= DW'(px_c) - DW'(cx_c);
      a_dy    <= DW'(py_c) - DW'(cy_c);
      a_angle <= angle_prod[31:0];
    end
  end

  // gain compensation, one multiplier per axis
  assign prod_x = PW'(a_dx) * PW'(GAIN_Q30);
  assign prod_y = PW'(a_dy) * PW'(GAIN_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rb) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rb && va) begin
      b_px    <= prod_x;
      b_py    <= prod_y;
      b_angle <= a_angle;
    end
  end

  // floor shift to 8 guard bits, then fold the angle into the right half plane
  assign x0  = $signed(b_px[PW-1:GAIN_SHIFT]);
  assign y0  = $signed(b_py[PW-1:GAIN_SHIFT]);
  assign x0e = XW'(x0);
  assign y0e = XW'(y0);
  assign angle_sum = b_angle + QUARTER_TURN;
  assign flip   = angle_sum[31];
  assign z_bits = flip ? (b_angle ^ HALF_TURN) : b_angle;

  always_comb begin
    c_next.x = flip ? -x0e : x0e;
    c_next.y = flip ? -y0e : y0e;
    c_next.z = ZW'($signed(z_bits));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (rc) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (rc && vb) begin
      c_data <= c_next;
    end
  end

  assign out_valid = vc;
  assign out_data  = c_data;

endmodule

`default_nettype wire

/* hw/rtl/prac_cordic.sv */
// unrolled cordic rotator, one registered micro-rotation per stage
// depends on prac_pkg
`default_nettype none

module prac_cordic (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire prac_pkg::rot_t    in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output prac_pkg::rot_t         out_data
);
  import prac_pkg::*;

  logic vq   [NSTAGES];
  rot_t dq   [NSTAGES];
  logic vin  [NSTAGES];
  rot_t din  [NSTAGES];
  logic rdy  [NSTAGES];
  logic rdn  [NSTAGES];

  for (genvar i = 0; i < NSTAGES; i++) begin : g_stage
    logic signed [XW-1:0] xo, yo, xs, ys;
    logic signed [ZW-1:0] zo, tz;
    rot_t                 nxt;

    if (i == 0) begin : g_first
      assign vin[i] = in_valid;
      assign din[i] = in_data;
    end else begin : g_chain
      assign vin[i] = vq[i-1];
      assign din[i] = dq[i-1];
    end

    if (i == NSTAGES - 1) begin : g_last
      assign rdn[i] = out_ready;
    end else begin : g_mid
      assign rdn[i] = rdy[i+1];
    end

    assign rdy[i] = !vq[i] || rdn[i];

    assign xo = din[i].x;
    assign yo = din[i].y;
    assign zo = din[i].z;
    assign xs = xo >>> i;
    assign ys = yo >>> i;
    assign tz = $signed(ZW'(atan_turn(i)));

    always_comb begin
      if (!zo[ZW-1]) begin
        nxt.x = xo - ys;
        nxt.y = yo + xs;
        nxt.z = zo - tz;
      end else begin
        nxt.x = xo + ys;
        nxt.y = yo - xs;
        nxt.z = zo + tz;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[i] <= 1'b0;
      end else if (rdy[i]) begin
        vq[i] <= vin[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && vin[i]) begin
        dq[i] <= nxt;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vq[NSTAGES-1];
  assign out_data  = dq[NSTAGES-1];

endmodule

`default_nettype wire

/* hw/rtl/prac_back.sv */
// back end: drop guard bits with rounding, add center, saturate, output register
// depends on prac_pkg and prac_res_if
`default_nettype none

module prac_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire prac_pkg::rot_t    in_data,
  input  wire logic [31:0]       center_x,
  input  wire logic [31:0]       center_y,
  prac_res_if.source             res
);
  import prac_pkg::*;

  logic                 vr;
  logic signed [RW-1:0] rx, ry;
  logic                 vo;
  logic [31:0]          ox, oy;
  logic                 osat;

  logic rr, ro;

  logic signed [XW-1:0] xi, yi, xsum, ysum, xsh, ysh;
  logic signed [CW-1:0] cx_c, cy_c, px, py;
  logic signed [RW:0]   sx, sy;
  logic                 hx, lx, hy, ly;

  assign ro = !vo || res.ready;
  assign rr = !vr || ro;
  assign in_ready = rr;

  assign xi   = in_data.x;
  assign yi   = in_data.y;
  assign xsum = xi + $signed(ROUND_HALF);
  assign ysum = yi + $signed(ROUND_HALF);
  assign xsh  = xsum >>> GUARD;
  assign ysh  = ysum >>> GUARD;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (rr) begin
      vr <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rr && in_valid) begin
      rx <= xsh[RW-1:0];
      ry <= ysh[RW-1:0];
    end
  end

  // center plus offset, clipped to the coordinate range
  assign cx_c = $signed(center_x[CW-1:0]);
  assign cy_c = $signed(center_y[CW-1:0]);
  assign sx = (RW+1)'(cx_c) + (RW+1)'(rx);
  assign sy = (RW+1)'(cy_c) + (RW+1)'(ry);
  assign hx = sx > (RW+1)'(COORD_MAX);
  assign lx = sx < (RW+1)'(COORD_MIN);
  assign hy = sy > (RW+1)'(COORD_MAX);
  assign ly = sy < (RW+1)'(COORD_MIN);

  always_comb begin
    if (hx) begin
      px = COORD_MAX;
    end else if (lx) begin
      px = COORD_MIN;
    end else begin
      px = sx[CW-1:0];
    end
    if (hy) begin
      py = COORD_MAX;
    end else if (ly) begin
      py = COORD_MIN;
    end else begin
      py = sy[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (ro) begin
      vo <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (ro && vr) begin
      ox   <= 32'(px);
      oy   <= 32'(py);
      osat <= hx || lx || hy || ly;
    end
  end

  assign res.valid     = vo;
  assign res.next_x    = ox;
  assign res.next_y    = oy;
  assign res.saturated = osat;

endmodule

`default_nettype wire

/* hw/rtl/point_rotation_about_center.sv */
// top level of the point rotation block: register file and the rotation pipeline
// depends on prac_pkg, prac_if, prac_front, prac_cordic, prac_back
`default_nettype none

// channel  modport         payload                              meaning
// pt       prac_pt_if.sink elapsed_ms, prev_x, prev_y           point request
// res      prac_res_if.src next_x, next_y, saturated            rotated point
// cfg      prac_cfg_if.snk addr, data                           register write
//
// one request enters per cycle while no stall holds the pipeline; a request passes
// three front stages (offset, gain multiply, pre-rotation), one register per
// cordic micro-rotation, a rounding stage and the output register
// rst is synchronous: it empties every stage and clears the three registers
// each stage holds while the one after it is full and stalled; empty stages
// are filled behind a stall, so a request can be taken while a result waits
// register writes are always accepted and belong while no request is in flight

module point_rotation_about_center (
  input  wire logic  clk,
  input  wire logic  rst,
  prac_pt_if.sink    pt,
  prac_res_if.source res,
  prac_cfg_if.sink   cfg
);
  import prac_pkg::*;

  // configuration registers
  logic [31:0] center_x;
  logic [31:0] center_y;
  logic [31:0] angular_velocity;

  // front end to rotator, rotator to back end
  logic fr_valid, fr_ready;
  rot_t fr_data;
  logic cr_valid, cr_ready;
  rot_t cr_data;

  // register writes never stall
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x         <= '0;
      center_y         <= '0;
      angular_velocity <= '0;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_CENTER_X: center_x         <= cfg.data;
        REG_CENTER_Y: center_y         <= cfg.data;
        REG_ANG_VEL:  angular_velocity <= cfg.data;
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  // offset from center, angle = velocity * time, gain removal, half-plane fold
  prac_front u_front (
    .clk              (clk),
    .rst              (rst),
    .pt               (pt),
    .center_x         (center_x),
    .center_y         (center_y),
    .angular_velocity (angular_velocity),
    .out_valid        (fr_valid),
    .out_ready        (fr_ready),
    .out_data         (fr_data)
  );

  // micro-rotations, driving the residual angle toward zero
  prac_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (cr_valid),
    .out_ready (cr_ready),
    .out_data  (cr_data)
  );

  // round off guard bits, move back to the center, clip and flag
  prac_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cr_valid),
    .in_ready (cr_ready),
    .in_data  (cr_data),
    .center_x (center_x),
    .center_y (center_y),
    .res      (res)
  );

endmodule

`default_nettype wire

/* hw/rtl/prac_checker.sv */
// port-level checks of the point rotation block and the bind that attaches them
// depends on prac_pkg and point_rotation_about_center
`default_nettype none

module prac_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pt_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] next_x,
  input wire logic [31:0] next_y,
  input wire logic        saturated
);
  import prac_pkg::*;

  localparam logic [31:0] XMAX = 32'(COORD_MAX);
  localparam logic [31:0] XMIN = 32'(COORD_MIN);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(next_x) && $stable(next_y)
      && $stable(saturated))
    else $error("stalled result changed");

  // with no result pending every stage can move, so a request is taken
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> pt_ready)
    else $error("request refused with an empty output");

  // a clipped result sits on a range bound
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid && saturated |-> next_x == XMAX || next_x == XMIN
      || next_y == XMAX || next_y == XMIN)
    else $error("saturated flag without a clipped coordinate");

endmodule

bind point_rotation_about_center prac_checker u_prac_checker (
  .clk       (clk),
  .rst       (rst),
  .pt_ready  (pt.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .next_x    (res.next_x),
  .next_y    (res.next_y),
  .saturated (res.saturated)
);

`default_nettype wire
